/* sv/ppmfb_pkg.sv */
// ----------------------------------------------------------------------------
// ppmfb_pkg
// Shared types and constants of the serpentine palette framebuffer.
// ----------------------------------------------------------------------------
package ppmfb_pkg;

  localparam int MATRIX_COLUMNS  = 32;
  localparam int MATRIX_ROWS     = 8;
  localparam int PALETTE_ENTRIES = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int ROW_W      = 3;
  localparam int COL_CALC_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COLOR_W    = 8;
  localparam int SLOT_W     = 4;

  localparam logic [7:0] BRIGHTNESS_RESET = 8'd10;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_CURSOR     = 2'd1,
    CFG_ROW_SHIFT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    action_e               op;
    logic [SLOT_W-1:0]     slot;
    logic [3*COLOR_W-1:0]  rgb;
    logic [SLOT_W-1:0]     nib_a;
    logic [SLOT_W-1:0]     nib_b;
    logic                  ok_a;
    logic                  ok_b;
  } cmd_t;

endpackage

/* sv/ppmfb_queue.sv */
// ----------------------------------------------------------------------------
// ppmfb_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ppmfb_queue #(
  parameter int DataW = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/ppmfb_front.sv */
// ----------------------------------------------------------------------------
// ppmfb_front
// Accepts commands, holds the configuration registers and turns each
// command into a queue entry with its store addresses worked out.
// ----------------------------------------------------------------------------
module ppmfb_front #(
  parameter int MatrixColumns = ppmfb_pkg::MATRIX_COLUMNS,
  parameter int AddrW         = $clog2(MatrixColumns) + 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [1:0]                       action_i,
  input  logic [ppmfb_pkg::SLOT_W-1:0]     palette_slot_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    red_in_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    green_in_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    blue_in_i,
  input  logic [7:0]                       pixel_byte_i,
  input  logic [4:0]                       byte_position_i,
  input  logic [7:0]                       pixel_number_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppmfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppmfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                             push_o,
  output ppmfb_pkg::cmd_t                  cmd_o,
  output logic [AddrW-1:0]                 addr_a_o,
  output logic [AddrW-1:0]                 addr_b_o,
  output logic [7:0]                       brightness_o
);

  import ppmfb_pkg::*;

  localparam int ColAw     = AddrW - ROW_W;
  localparam int StoreSize = MatrixColumns * MATRIX_ROWS;
  localparam int NumW      = ((AddrW > 8) ? AddrW : 8) + 1;

  logic [7:0] brightness_q;
  logic [4:0] cursor_q;
  logic [3:0] row_shift_q;

  logic                  accept;
  action_e               op;
  logic [4:0]            row_sum;
  logic                  row_ok;
  logic [ROW_W-1:0]      row;
  logic [COL_CALC_W-1:0] col_a, col_b;
  logic                  ok_a, ok_b;
  logic [NumW-1:0]       num_ext;
  logic                  num_ok;

  function automatic logic [AddrW-1:0] serp_addr(input logic [COL_CALC_W-1:0] col,
                                                 input logic [ROW_W-1:0] r);
    serp_addr = {col[ColAw-1:0], (col[0] ? ~r : r)};
  endfunction

  assign cfg_ready_o  = 1'b1;
  assign brightness_o = brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHTNESS_RESET;
      cursor_q     <= '0;
      row_shift_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BRIGHTNESS: brightness_q <= cfg_data_i;
        CFG_CURSOR:     cursor_q     <= cfg_data_i[4:0];
        CFG_ROW_SHIFT:  row_shift_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign accept  = start_i && !busy_i;
  assign op      = action_e'(action_i);

  // shifted image row, kept only when it lands on the matrix
  assign row_sum = {2'b00, byte_position_i[4:2]} + {row_shift_q[3], row_shift_q};
  assign row_ok  = (row_sum[4:3] == 2'b00);
  assign row     = row_sum[ROW_W-1:0];

  assign col_a = COL_CALC_W'(cursor_q) + COL_CALC_W'({byte_position_i[1:0], 1'b0});
  assign col_b = col_a + COL_CALC_W'(1);
  assign ok_a  = row_ok && (col_a < COL_CALC_W'(MatrixColumns));
  assign ok_b  = row_ok && (col_b < COL_CALC_W'(MatrixColumns));

  assign num_ext = NumW'(pixel_number_i);
  assign num_ok  = (num_ext < NumW'(StoreSize));

  always_comb begin
    cmd_o.op    = op;
    cmd_o.slot  = palette_slot_i;
    cmd_o.rgb   = {red_in_i, green_in_i, blue_in_i};
    cmd_o.nib_a = pixel_byte_i[7:4];
    cmd_o.nib_b = pixel_byte_i[3:0];
    cmd_o.ok_a  = ok_a;
    cmd_o.ok_b  = ok_b;
    addr_a_o    = serp_addr(col_a, row);
    addr_b_o    = serp_addr(col_b, row);
    push_o      = accept;
    unique case (op)
      ACT_DRAW: begin
        push_o = accept && (ok_a || ok_b);
      end
      ACT_READ: begin
        cmd_o.ok_a = num_ok;
        addr_a_o   = num_ext[AddrW-1:0];
      end
      default: ;
    endcase
  end

endmodule

/* sv/ppmfb_back.sv */
// ----------------------------------------------------------------------------
// ppmfb_back
// Executes queued commands: palette writes, scaled pixel writes, store
// sweeps and pixel reads.
// ----------------------------------------------------------------------------
module ppmfb_back #(
  parameter int MatrixColumns = ppmfb_pkg::MATRIX_COLUMNS,
  parameter int AddrW         = $clog2(MatrixColumns) + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  ppmfb_pkg::cmd_t               head_cmd_i,
  input  logic [AddrW-1:0]              head_addr_a_i,
  input  logic [AddrW-1:0]              head_addr_b_i,
  input  logic [7:0]                    brightness_i,
  output logic                          pop_o,
  output logic                          init_busy_o,
  output logic                          out_valid_o,
  output logic [ppmfb_pkg::COLOR_W-1:0] red_out_o,
  output logic [ppmfb_pkg::COLOR_W-1:0] green_out_o,
  output logic [ppmfb_pkg::COLOR_W-1:0] blue_out_o
);

  import ppmfb_pkg::*;

  localparam int StoreSize = MatrixColumns * MATRIX_ROWS;
  localparam int PixW      = 3 * COLOR_W;
  localparam int ProdW     = 2 * COLOR_W;

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_DRAW_B = 4'b0100,
    ST_CLEAR  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [AddrW-1:0] sweep_q, sweep_d;

  logic [PixW-1:0]  palette_q [PALETTE_ENTRIES];
  logic [PixW-1:0]  store_mem [StoreSize];

  logic             issue;
  logic [SLOT_W-1:0] issue_idx;
  logic [AddrW-1:0] issue_addr;
  logic [PixW-1:0]  pal_entry;
  logic             pal_we;
  logic             rd_en;
  logic             sweep_we;

  logic             mul_valid_q;
  logic [AddrW-1:0] mul_addr_q;
  logic [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [PixW-1:0]  mem_wdata;

  logic             out_valid_q;
  logic             rd_zero_q;
  logic [PixW-1:0]  rd_data_q;

  // floor(p / 255) for p up to 255*255
  function automatic logic [COLOR_W-1:0] div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = (ProdW+1)'(p) + (ProdW+1)'(p >> COLOR_W) + (ProdW+1)'(1);
    div255 = s[ProdW-1:COLOR_W];
  endfunction

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    pop_o      = 1'b0;
    issue      = 1'b0;
    issue_idx  = head_cmd_i.nib_a;
    issue_addr = head_addr_a_i;
    pal_we     = 1'b0;
    rd_en      = 1'b0;
    sweep_we   = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        sweep_we = 1'b1;
        if (sweep_q == AddrW'(StoreSize - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_cmd_i.op)
            ACT_LOAD: begin
              pop_o  = 1'b1;
              pal_we = 1'b1;
            end
            ACT_DRAW: begin
              issue = head_cmd_i.ok_a;
              if (head_cmd_i.ok_b) begin
                state_d = ST_DRAW_B;
              end else begin
                pop_o = 1'b1;
              end
            end
            ACT_CLEAR: begin
              if (!mul_valid_q) begin
                pop_o   = 1'b1;
                state_d = ST_CLEAR;
              end
            end
            ACT_READ: begin
              if (!mul_valid_q) begin
                pop_o = 1'b1;
                rd_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAW_B: begin
        issue      = 1'b1;
        issue_idx  = head_cmd_i.nib_b;
        issue_addr = head_addr_b_i;
        pop_o      = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      mul_valid_q <= issue;
      out_valid_q <= rd_en;
    end
  end

  assign init_busy_o = (state_q == ST_INIT);

  // palette
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      palette_q[head_cmd_i.slot] <= head_cmd_i.rgb;
    end
  end

  assign pal_entry = palette_q[issue_idx];

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      mul_addr_q <= issue_addr;
      prod_r_q   <= ProdW'(pal_entry[3*COLOR_W-1 -: COLOR_W]) * ProdW'(brightness_i);
      prod_g_q   <= ProdW'(pal_entry[2*COLOR_W-1 -: COLOR_W]) * ProdW'(brightness_i);
      prod_b_q   <= ProdW'(pal_entry[COLOR_W-1:0]) * ProdW'(brightness_i);
    end
  end

  // single write port shared by the sweep and the pixel writes
  assign mem_we    = sweep_we || mul_valid_q;
  assign mem_waddr = sweep_we ? sweep_q : mul_addr_q;
  assign mem_wdata = sweep_we ? '0 : {div255(prod_r_q), div255(prod_g_q), div255(prod_b_q)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[head_addr_a_i];
      rd_zero_q <= !head_cmd_i.ok_a;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = rd_zero_q ? '0 : rd_data_q[3*COLOR_W-1 -: COLOR_W];
  assign green_out_o = rd_zero_q ? '0 : rd_data_q[2*COLOR_W-1 -: COLOR_W];
  assign blue_out_o  = rd_zero_q ? '0 : rd_data_q[COLOR_W-1:0];

endmodule

/* sv/palette_pixel_matrix_framebuffer_top.sv */
// A read result strobes on out_valid_o after the queue entry and the read-data
//   register; the receiver cannot stall it. Commands are taken at 1 per
//   cycle while busy is low; a draw touching two columns also steps through
//   ST_DRAW_B; a read or clear right behind a draw waits for its pixel write.
// A clear sweeps all MatrixColumns*8 (256) store entries at 1 entry per cycle.
// Reset runs the same sweep with busy high before the first command.
// ----------------------------------------------------------------------------
// palette_pixel_matrix_framebuffer_top
// Palette framebuffer for a serpentine-wired LED matrix: front end, command
// queue and execution back end.
// ----------------------------------------------------------------------------
module palette_pixel_matrix_framebuffer_top #(
  parameter int MatrixColumns = ppmfb_pkg::MATRIX_COLUMNS,
  parameter int QueueDepth    = ppmfb_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action_i,
  input  logic [ppmfb_pkg::SLOT_W-1:0]     palette_slot_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    red_in_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    green_in_i,
  input  logic [ppmfb_pkg::COLOR_W-1:0]    blue_in_i,
  input  logic [7:0]                       pixel_byte_i,
  input  logic [4:0]                       byte_position_i,
  input  logic [7:0]                       pixel_number_i,
  output logic                             out_valid_o,
  output logic [ppmfb_pkg::COLOR_W-1:0]    red_out_o,
  output logic [ppmfb_pkg::COLOR_W-1:0]    green_out_o,
  output logic [ppmfb_pkg::COLOR_W-1:0]    blue_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppmfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppmfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ppmfb_pkg::*;

  localparam int AddrW = $clog2(MatrixColumns) + ROW_W;
  localparam int CmdW  = $bits(cmd_t);
  localparam int QW    = CmdW + 2 * AddrW;

  logic             push;
  cmd_t             push_cmd;
  logic [AddrW-1:0] push_addr_a, push_addr_b;
  logic [7:0]       brightness;
  logic [QW-1:0]    q_data;
  logic             q_empty, q_full;
  logic             pop;
  logic             init_busy;
  cmd_t             head_cmd;
  logic [AddrW-1:0] head_addr_a, head_addr_b;

  assign busy = q_full || init_busy;

  ppmfb_front #(
    .MatrixColumns(MatrixColumns),
    .AddrW        (AddrW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action_i),
    .palette_slot_i (palette_slot_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .pixel_byte_i   (pixel_byte_i),
    .byte_position_i(byte_position_i),
    .pixel_number_i (pixel_number_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .addr_a_o       (push_addr_a),
    .addr_b_o       (push_addr_b),
    .brightness_o   (brightness)
  );

  ppmfb_queue #(
    .DataW(QW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_cmd, push_addr_b, push_addr_a}),
    .pop_i  (pop),
    .data_o (q_data),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign head_cmd    = cmd_t'(q_data[QW-1 -: CmdW]);
  assign head_addr_b = q_data[2*AddrW-1 -: AddrW];
  assign head_addr_a = q_data[AddrW-1:0];

  ppmfb_back #(
    .MatrixColumns(MatrixColumns),
    .AddrW        (AddrW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_cmd_i   (head_cmd),
    .head_addr_a_i(head_addr_a),
    .head_addr_b_i(head_addr_b),
    .brightness_i (brightness),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o)
  );

endmodule
